// ===== rtl/arm_inverse_kinematics_unit_assert.svh =====
// Assertion macros for the arm inverse kinematics unit.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef ARM_INVERSE_KINEMATICS_UNIT_ASSERT_SVH
`define ARM_INVERSE_KINEMATICS_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define AIK_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// implication checked in the cycle after
`define AIK_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ===== rtl/aik_pkg.sv =====
// Package for the arm inverse kinematics unit: widths, register indexes,
// sequencer command types and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
package aik_pkg;
  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned RegW = 15;
  localparam int unsigned PosW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegBaseHeight = 2'd0;
  localparam logic [CfgIdxW-1:0] RegUpperArm   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegForearm    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHand       = 2'd3;

  localparam logic [14:0] ResetBaseHeight = 15'd1000;
  localparam logic [14:0] ResetUpperArm   = 15'd1500;
  localparam logic [14:0] ResetForearm    = 15'd1500;
  localparam logic [14:0] ResetHand       = 15'd800;

  // datapath operations, one per sequencer step
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpSq, OpSum, OpSel, OpNorm, OpRoot, OpRot, OpDone
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] angle; // which of the four arccos terms
  } dp_cmd_t;

  typedef struct packed {
    logic done;   // current op finished
    logic ok;     // target reachable
  } dp_sts_t;

  function automatic logic [22:0] atan_lut(input logic [4:0] i);
    logic [22:0] v;
    case (i)
      5'd0: v = 23'd2949120;  5'd1: v = 23'd1740967; 5'd2: v = 23'd919879;
      5'd3: v = 23'd466945;   5'd4: v = 23'd234379;  5'd5: v = 23'd117304;
      5'd6: v = 23'd58666;    5'd7: v = 23'd29335;   5'd8: v = 23'd14668;
      5'd9: v = 23'd7334;     5'd10: v = 23'd3667;   5'd11: v = 23'd1833;
      5'd12: v = 23'd917;     5'd13: v = 23'd458;    5'd14: v = 23'd229;
      5'd15: v = 23'd115;     5'd16: v = 23'd57;     5'd17: v = 23'd29;
      5'd18: v = 23'd14;      5'd19: v = 23'd7;      5'd20: v = 23'd4;
      5'd21: v = 23'd2;       5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction
endpackage

// ===== rtl/arm_inverse_kinematics_unit.sv =====
// Arm inverse kinematics unit: target (x,y,z) in, four joint angles out.
// A reachable target goes through the four arccos terms in turn, each term scaling by 4
// up to 30 times; an unreachable target skips them after the reach test.
// One word at a time: the next word is taken only after the result goes valid;
// a result not yet taken stalls the next one in its last step.
// Reset (rst_ni low, asynchronous) restores register defaults, zeroes held angles.
`timescale 1ns / 1ps
`include "arm_inverse_kinematics_unit_assert.svh"
module arm_inverse_kinematics_unit #(
  parameter int unsigned CORDIC_STEPS = aik_pkg::CordicStepsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // pos_x, pos_y, pos_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // base, shoulder, elbow, wrist, zero pad
  output logic        m_axis_tuser,  // reachable
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);
  import aik_pkg::*;

  logic [14:0] h_q, a_q, f_q, m_q;
  logic signed [15:0] px_q, py_q, pz_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [14:0] angle;
  logic busy, start;
  logic [14:0] base, elbow;
  logic signed [15:0] shoulder;
  logic signed [16:0] wrist;
  logic reachable;

  // accept a word only while the sequencer is idle
  assign s_axis_tready = !busy;
  assign start = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= ResetBaseHeight;
      a_q <= ResetUpperArm;
      f_q <= ResetForearm;
      m_q <= ResetHand;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegBaseHeight: h_q <= cfg_data_i;
        RegUpperArm:   a_q <= cfg_data_i;
        RegForearm:    f_q <= cfg_data_i;
        RegHand:       m_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // capture the target word; it stays put while the item is worked on
  always_ff @(posedge clk_i) begin
    if (start) begin
      px_q <= s_axis_tdata[15:0];
      py_q <= s_axis_tdata[31:16];
      pz_q <= s_axis_tdata[47:32];
    end
  end

  aik_datapath #(.CordicSteps(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .pos_x_i(px_q), .pos_y_i(py_q), .pos_z_i(pz_q),
    .h_i(h_q), .a_i(a_q), .f_i(f_q), .m_i(m_q), .angle_o(angle)
  );

  aik_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy),
    .res_valid_o(m_axis_tvalid), .res_take_i(m_axis_tvalid && m_axis_tready),
    .cmd_o(cmd), .sts_i(sts), .angle_i(angle),
    .base_o(base), .shoulder_o(shoulder), .elbow_o(elbow), .wrist_o(wrist),
    .reachable_o(reachable)
  );

  assign m_axis_tdata = {1'b0, wrist, elbow, shoulder, base};
  assign m_axis_tuser = reachable;

  // no new word while busy, and an accepted word makes the unit busy
  `AIK_ASSERT_IMPL(a_no_accept_busy, busy, !s_axis_tready)
  `AIK_ASSERT_NEXT(a_start_busy, start, busy)
endmodule

// ===== rtl/aik_datapath.sv =====
// Datapath of the arm inverse kinematics unit: squares, reach test, scaling,
// bit-serial square root and a shared vectoring CORDIC. Uses aik_pkg.
`timescale 1ns / 1ps
module aik_datapath #(
  parameter int unsigned CordicSteps = aik_pkg::CordicStepsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aik_pkg::dp_cmd_t     cmd_i,
  output aik_pkg::dp_sts_t     sts_o,
  input  logic signed [15:0]   pos_x_i,
  input  logic signed [15:0]   pos_y_i,
  input  logic signed [15:0]   pos_z_i,
  input  logic [14:0]          h_i,
  input  logic [14:0]          a_i,
  input  logic [14:0]          f_i,
  input  logic [14:0]          m_i,
  output logic [14:0]          angle_o // last arccos result, 0..18000
);
  import aik_pkg::*;
  localparam int unsigned RotSteps = (CordicSteps < 32) ? CordicSteps : 32;
  localparam int unsigned StepW = $clog2(RotSteps + 1);

  // operands
  logic signed [16:0] x_q, y_q, p_q;
  logic signed [16:0] pz_w;
  logic [33:0] r2_q, pp_q, aa_q, ff_q;
  logic [35:0] d2_q;
  logic [31:0] lo_q, hi_q;
  logic [1:0]  sqs_q; // square step
  logic        ok_q;

  // current arccos operands: n (signed) and s
  logic signed [37:0] n_w;
  logic [63:0] s_w;
  logic [63:0] s_q, q_q;
  logic [31:0] mag_q;
  logic        neg_q;
  logic [4:0]  k_q;
  // square root
  logic [63:0] rv_q, rr_q, rb_q;
  // CORDIC
  logic signed [66:0] cx_q, cy_q;
  logic signed [31:0] acc_q;
  logic [StepW-1:0] it_q;
  logic [4:0]  it5_w;
  logic        done_q;
  logic [1:0]  mstep_q;
  logic [63:0] sqm_q;
  logic [14:0] ang_q;

  assign pz_w = 17'(signed'({1'b0, h_i})) - 17'(pos_z_i) - 17'(signed'({1'b0, m_i}));
  assign it5_w = 5'(it_q);

  // argument selection per angle; the products use 32x32 multiplies on the low
  // operand bits (d2 is below 2^32 whenever the target is in reach)
  logic [31:0] d2a_w;
  always_comb begin
    n_w = '0;
    s_w = '0;
    d2a_w = d2_q[31:0];
    case (cmd_i.angle)
      2'd0: begin n_w = 38'(x_q); s_w = 64'(r2_q); end
      2'd1: begin
        n_w = signed'(38'(d2_q)) + signed'(38'(aa_q)) - signed'(38'(ff_q));
        s_w = sqm_q;
      end
      2'd2: begin n_w = 38'(p_q); s_w = 64'(d2_q); end
      default: begin
        n_w = signed'(38'(aa_q)) + signed'(38'(ff_q)) - signed'(38'(d2_q));
        s_w = sqm_q;
      end
    endcase
  end

  logic [37:0] nabs_w;
  assign nabs_w = n_w[37] ? 38'(-n_w) : 38'(n_w);
  logic [31:0] magc_w;
  assign magc_w = (|nabs_w[37:32]) ? 32'hFFFF_FFFF : nabs_w[31:0];
  logic [63:0] magsq_w;
  assign magsq_w = 64'(magc_w) * 64'(magc_w);

  logic signed [66:0] xs_w, ys_w;
  assign xs_w = cx_q >>> it_q;
  assign ys_w = cy_q >>> it_q;
  logic signed [38:0] cent_w;
  assign cent_w = 39'(acc_q) * 39'sd100 + 39'sd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      ok_q <= 1'b0;
    end else if (done_q) begin
      // idle while the sequencer moves on to the next op
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (cmd_i.op)
        OpLoad: begin
          x_q <= 17'(pos_x_i);
          y_q <= 17'(pos_y_i);
          p_q <= pz_w;
          sqs_q <= 2'd0;
          done_q <= 1'b1;
        end
        OpSq: begin
          // squares in turn: x, then y, then p, then both link lengths together
          sqs_q <= sqs_q + 2'd1;
          case (sqs_q)
            2'd0: r2_q <= 34'(x_q * x_q);
            2'd1: r2_q <= r2_q + 34'(y_q * y_q);
            2'd2: pp_q <= 34'(p_q * p_q);
            default: begin
              aa_q <= 34'(a_i * a_i);
              ff_q <= 34'(f_i * f_i);
              done_q <= 1'b1;
            end
          endcase
        end
        OpSum: begin
          d2_q <= 36'(r2_q) + 36'(pp_q);
          lo_q <= 32'((17'(a_i) - 17'(f_i)) * (17'(a_i) - 17'(f_i)));
          hi_q <= 32'((17'(a_i) + 17'(f_i)) * (17'(a_i) + 17'(f_i)));
          mstep_q <= 2'd0;
          done_q <= 1'b1;
        end
        OpSel: begin
          // 4*d2*A^2 or 4*A^2*F^2 and the reach test, then mag^2 and q
          mstep_q <= mstep_q + 2'd1;
          case (mstep_q)
            2'd0: begin
              if (cmd_i.angle == 2'd1)
                sqm_q <= (64'(d2a_w) * 64'(aa_q[31:0])) << 2;
              else
                sqm_q <= (64'(aa_q[31:0]) * 64'(ff_q[31:0])) << 2;
              ok_q <= (r2_q != 0) && (h_i != 0) && (a_i != 0) && (f_i != 0)
                      && (d2_q >= 36'(lo_q)) && (d2_q <= 36'(hi_q));
            end
            default: begin
              mag_q <= magc_w;
              neg_q <= n_w[37];
              s_q <= s_w;
              q_q <= (magsq_w > s_w) ? 64'd0 : s_w - magsq_w;
              k_q <= '0;
              mstep_q <= 2'd0;
              done_q <= 1'b1;
            end
          endcase
        end
        OpNorm: begin
          if (s_q < (64'd1 << 60) && s_q != 0) begin
            s_q <= s_q << 2;
            q_q <= q_q << 2;
            k_q <= k_q + 5'd1;
          end else begin
            rv_q <= q_q;
            rr_q <= '0;
            rb_q <= 64'd1 << 62;
            done_q <= 1'b1;
          end
        end
        OpRoot: begin
          // leading steps with a zero root only shift the probe bit down
          if (rb_q != 0) begin
            if (rv_q >= rr_q + rb_q) begin
              rv_q <= rv_q - (rr_q + rb_q);
              rr_q <= (rr_q >> 1) + rb_q;
            end else begin
              rr_q <= rr_q >> 1;
            end
            rb_q <= rb_q >> 2;
          end else begin
            if (neg_q) begin
              cx_q <= 67'(rr_q);
              cy_q <= 67'(64'(mag_q) << k_q);
              acc_q <= 32'sd5898240;
            end else begin
              cx_q <= 67'(64'(mag_q) << k_q);
              cy_q <= 67'(rr_q);
              acc_q <= '0;
            end
            it_q <= '0;
            done_q <= 1'b1;
          end
        end
        OpRot: begin
          if (it_q < StepW'(RotSteps)) begin
            if (!cy_q[66]) begin
              cx_q <= cx_q + ys_w;
              cy_q <= cy_q - xs_w;
              acc_q <= acc_q + 32'(atan_lut(it5_w));
            end else begin
              cx_q <= cx_q - ys_w;
              cy_q <= cy_q + xs_w;
              acc_q <= acc_q - 32'(atan_lut(it5_w));
            end
            it_q <= it_q + StepW'(1);
          end else begin
            if (s_q == 0 || cent_w <= 0) ang_q <= '0;
            else if ((cent_w >>> 16) > 39'sd18000) ang_q <= 15'd18000;
            else ang_q <= 15'(cent_w >>> 16);
            done_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign angle_o = ang_q;
  assign sts_o = '{done: done_q, ok: ok_q};
endmodule

// ===== rtl/aik_ctrl.sv =====
// Sequencer of the arm inverse kinematics unit: walks the datapath through
// the four arccos terms and assembles the joint angles. Uses aik_pkg.
`timescale 1ns / 1ps
module aik_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output aik_pkg::dp_cmd_t    cmd_o,
  input  aik_pkg::dp_sts_t    sts_i,
  input  logic [14:0]         angle_i,
  output logic [14:0]         base_o,
  output logic signed [15:0]  shoulder_o,
  output logic [14:0]         elbow_o,
  output logic signed [16:0]  wrist_o,
  output logic                reachable_o
);
  import aik_pkg::*;
  typedef enum logic [3:0] {
    StIdle, StLoad, StSq, StSum, StSel, StNorm, StRoot, StRot, StWait, StOut
  } state_e;
  state_e st_q;
  logic [1:0] ang_q;
  logic [14:0] b_q, c1_q, c2_q, e_q;
  logic [14:0] hb_q, he_q;
  logic signed [15:0] hs_q;
  logic signed [16:0] hw_q;
  logic ok_q, rv_q, hr_q;
  logic signed [15:0] s_w;
  assign s_w = 16'(c1_q) + 16'(c2_q) - 16'sd9000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ang_q <= '0;
      hb_q <= '0; hs_q <= '0; he_q <= '0; hw_q <= '0;
      ok_q <= 1'b0;
      rv_q <= 1'b0;
      hr_q <= 1'b0;
    end else begin
      if (res_take_i) rv_q <= 1'b0;
      case (st_q)
        StIdle: if (start_i) st_q <= StLoad;
        StLoad: if (sts_i.done) st_q <= StSq;
        StSq:   if (sts_i.done) st_q <= StSum;
        StSum:  if (sts_i.done) begin ang_q <= '0; st_q <= StSel; end
        StSel:  if (sts_i.done) begin
          ok_q <= sts_i.ok;
          st_q <= sts_i.ok ? StNorm : StWait;
        end
        StNorm: if (sts_i.done) st_q <= StRoot;
        StRoot: if (sts_i.done) st_q <= StRot;
        StRot:  if (sts_i.done) begin
          case (ang_q)
            2'd0: b_q <= angle_i;
            2'd1: c1_q <= angle_i;
            2'd2: c2_q <= angle_i;
            default: e_q <= angle_i;
          endcase
          ang_q <= ang_q + 2'd1;
          st_q <= (ang_q == 2'd3) ? StWait : StSel;
        end
        StWait: begin
          // hold until the previous result is taken
          if (!rv_q || res_take_i) begin
            if (ok_q) begin
              hb_q <= b_q;
              hs_q <= s_w;
              he_q <= e_q;
              hw_q <= 17'sd27000 - 17'(s_w) - 17'(e_q);
            end
            hr_q <= ok_q;
            rv_q <= 1'b1;
            st_q <= StOut;
          end
        end
        StOut: st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o = '{op: OpNone, angle: ang_q};
    case (st_q)
      StLoad: cmd_o.op = OpLoad;
      StSq:   cmd_o.op = OpSq;
      StSum:  cmd_o.op = OpSum;
      StSel:  cmd_o.op = OpSel;
      StNorm: cmd_o.op = OpNorm;
      StRoot: cmd_o.op = OpRoot;
      StRot:  cmd_o.op = OpRot;
      default: cmd_o.op = OpNone;
    endcase
  end

  assign busy_o = (st_q != StIdle);
  assign res_valid_o = rv_q;
  assign base_o = hb_q;
  assign shoulder_o = hs_q;
  assign elbow_o = he_q;
  assign wrist_o = hw_q;
  assign reachable_o = hr_q;
endmodule

// ===== dv/arm_inverse_kinematics_unit_test.sv =====
// Self-checking testbench for the arm inverse kinematics unit.
// Drives gripper targets through the stream ports and compares each word of joint angles with
// an in-bench solver or a typed expectation; depends on aik_pkg and the unit's RTL only.
`timescale 1ns / 1ps
module arm_inverse_kinematics_unit_test;
  import aik_pkg::*;

  localparam int unsigned CordicSteps = CordicStepsDefault;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 400;  // a bit more than one solve

  // arctangent steps in 2^-16 degree, rounded to nearest
  localparam longint ArctanStep[32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  typedef struct packed {
    logic        reachable;
    logic [16:0] wrist;
    logic [14:0] elbow;
    logic [15:0] shoulder;
    logic [14:0] base;
  } joint_word_t;

  typedef struct {
    shortint     x, y, z;
    bit          typed;     // expected word written out in the row
    joint_word_t angles;
  } target_row_t;

  typedef struct {
    int unsigned h, a, f, m;
    int unsigned count, send_idle, recv_idle;
  } arm_phase_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // pos_x, pos_y, pos_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // base, shoulder, elbow, wrist, zero pad
  logic        m_axis_tuser;        // reachable
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = RegBaseHeight;
  logic [14:0] cfg_data_i = '0;

  // bench copy of the arm geometry and the held solution
  longint arm_height, arm_upper, arm_fore, arm_hand;
  int     held_base, held_shoulder, held_elbow, held_wrist;

  joint_word_t pending_angles[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  arm_inverse_kinematics_unit dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Bit-serial floor square root of a 64 bit value.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // arccos(n / sqrt(s)) in 0.01 degree via normalize, root and vectoring CORDIC.
  function automatic int arccos_centideg(longint n, longint unsigned s);
    longint unsigned mag, q, sq;
    longint x, y, xs, ys, acc, v;
    int k;
    if (s == 0) return 0;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
    sq = mag * mag;
    q = (sq > s) ? 0 : s - sq;
    k = 0;
    while (s < (64'd1 << 60)) begin
      s <<= 2;
      q <<= 2;
      k++;
    end
    mag <<= k;
    y = floor_sqrt(q);
    acc = 0;
    // negative cosine: start a quarter turn on
    if (n < 0) begin
      x = y;
      y = mag;
      acc = 90 * 65536;
    end else begin
      x = mag;
    end
    for (int i = 0; i < CordicSteps && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        acc += ArctanStep[i];
      end else begin
        x -= ys;
        y += xs;
        acc -= ArctanStep[i];
      end
    end
    v = acc * 100 + 32768;
    if (v <= 0) return 0;
    v = v / 65536;
    return (v > 18000) ? 18000 : int'(v);
  endfunction

  // Reach test alone, used to aim random targets.
  function automatic bit target_in_reach(longint x, longint y, longint z);
    longint unsigned r2, d2;
    longint p;
    r2 = longint'(x * x) + longint'(y * y);
    p = arm_height - (z + arm_hand);
    d2 = r2 + longint'(p * p);
    return r2 != 0 && arm_height != 0 && arm_upper != 0 && arm_fore != 0 &&
           d2 >= longint'((arm_upper - arm_fore) * (arm_upper - arm_fore)) &&
           d2 <= longint'((arm_upper + arm_fore) * (arm_upper + arm_fore));
  endfunction

  // Solve one target, update the held angles when reachable, return the word.
  function automatic joint_word_t solve_joint_angles(shortint sx, shortint sy, shortint sz);
    longint x, y, z, p, aa, ff, shoulder;
    longint unsigned r2, d2;
    joint_word_t w;
    bit ok;
    x = sx;
    y = sy;
    z = sz;
    aa = arm_upper * arm_upper;
    ff = arm_fore * arm_fore;
    r2 = longint'(x * x) + longint'(y * y);
    p = arm_height - (z + arm_hand);
    d2 = r2 + longint'(p * p);
    ok = target_in_reach(x, y, z);
    if (ok) begin
      shoulder = arccos_centideg(longint'(d2) + aa - ff, 64'd4 * d2 * aa)
               + arccos_centideg(p, d2) - 9000;
      held_base = arccos_centideg(x, r2);
      held_elbow = arccos_centideg(aa + ff - longint'(d2), 64'd4 * aa * ff);
      held_shoulder = int'(shoulder);
      held_wrist = 27000 - held_shoulder - held_elbow;
    end
    w.base = held_base[14:0];
    w.shoulder = held_shoulder[15:0];
    w.elbow = held_elbow[14:0];
    w.wrist = held_wrist[16:0];
    w.reachable = ok;
    return w;
  endfunction

  // Write one register; hold valid until the unit takes it.
  task automatic write_register(logic [1:0] idx, int unsigned value);
    bit taken;
    cfg_index_i <= idx;
    cfg_data_i <= value[14:0];
    cfg_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegBaseHeight: arm_height = value;
      RegUpperArm:   arm_upper = value;
      RegForearm:    arm_fore = value;
      default:       arm_hand = value;
    endcase
    @(posedge clk_i);
  endtask

  // Drain, let the unit settle, then load a new geometry.
  task automatic load_geometry(arm_phase_t ph);
    wait (pending_angles.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    write_register(RegBaseHeight, ph.h);
    write_register(RegUpperArm, ph.a);
    write_register(RegForearm, ph.f);
    write_register(RegHand, ph.m);
  endtask

  // Send one target word; queue the typed or solved expectation on acceptance.
  task automatic send_target(shortint x, shortint y, shortint z, bit typed,
                             joint_word_t typed_angles);
    bit taken;
    joint_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= {z, y, x};
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    w = solve_joint_angles(x, y, z);
    pending_angles.push_back(typed ? typed_angles : w);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Signed value in -r..r clipped to the 16 bit field.
  function automatic longint span(longint r);
    if (r > 32767) r = 32767;
    return longint'($urandom_range(2 * r)) - r;
  endfunction

  // Mostly targets inside the reach shell, the rest raw noise over the full field.
  task automatic send_random_target();
    longint x, y, z, reach;
    int tries;
    x = shortint'($urandom());
    y = shortint'($urandom());
    z = shortint'($urandom());
    if ($urandom_range(99) < 80) begin
      reach = arm_upper + arm_fore;
      for (tries = 0; tries < 30; tries++) begin
        x = span(reach);
        y = span(reach);
        z = arm_height - arm_hand - span(reach);
        if (z >= -32768 && z <= 32767 && target_in_reach(x, y, z)) break;
      end
      if (z < -32768 || z > 32767) z = shortint'($urandom());
    end
    send_target(shortint'(x), shortint'(y), shortint'(z), 1'b0, '0);
  endtask

  // Receiver: drop tready at random, at the phase's idle rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each accepted word against the oldest expectation.
  always @(negedge clk_i) begin
    joint_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[62:0]};
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = pending_angles.pop_front();
        if (got != want || m_axis_tdata[63] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: base %0d/%0d shoulder %0d/%0d elbow %0d/%0d ",
                      "wrist %0d/%0d reach %0b/%0b pad %0b (exp/got)"},
                     want.base, got.base, $signed(want.shoulder), $signed(got.shoulder),
                     want.elbow, got.elbow, $signed(want.wrist), $signed(got.wrist),
                     want.reachable, got.reachable, m_axis_tdata[63]);
        end
      end
    end
  end

  // Hard stop if the unit hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Directed targets under reset geometry: z-axis, far corners, every quadrant,
  // the outer reach edge and a return to the z-axis with angles held.
  target_row_t directed[] = '{
    '{0, 0, 0, 1'b1, '0},                 // z-axis straight after reset: zeros held
    '{32767, 32767, 32767, 1'b1, '0},     // out of reach, still zeros held
    '{-32768, -32768, -32768, 1'b1, '0},
    '{1000, 0, 200, 1'b0, '0},
    '{0, 1000, 200, 1'b0, '0},
    '{-1000, 0, 200, 1'b0, '0},
    '{0, -2000, 0, 1'b0, '0},
    '{1500, 1500, -500, 1'b0, '0},
    '{3000, 0, 200, 1'b0, '0},            // exactly at full stretch
    '{3001, 0, 200, 1'b0, '0},            // just beyond it
    '{1, 0, 200, 1'b0, '0},               // folded tight at the shoulder
    '{-1, -1, 32767, 1'b0, '0},
    '{0, 0, 500, 1'b0, '0},               // z-axis again: last solution returned
    '{-2500, 1200, -1500, 1'b0, '0}
  };

  arm_phase_t phases[] = '{
    '{1000, 1500, 1500, 800, 400, 21, 52},
    '{1, 32767, 32767, 0, 150, 52, 21},
    '{32767, 1, 1, 32767, 60, 52, 21},
    '{0, 1500, 1200, 400, 40, 52, 21},    // zero shoulder height
    '{2000, 1800, 900, 0, 200, 52, 21},
    '{1200, 0, 1500, 500, 20, 0, 0},      // zero upper arm
    '{1200, 1400, 0, 500, 20, 0, 0},      // zero forearm
    '{0, 0, 0, 0, 360, 0, 0}              // filled with random geometry below
  };

  initial begin
    arm_phase_t ph;
    arm_height = ResetBaseHeight;
    arm_upper = ResetUpperArm;
    arm_fore = ResetForearm;
    arm_hand = ResetHand;
    held_base = 0;
    held_shoulder = 0;
    held_elbow = 0;
    held_wrist = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = phases[0].send_idle;
    recv_idle_pct = phases[0].recv_idle;
    foreach (directed[i])
      send_target(directed[i].x, directed[i].y, directed[i].z,
                  directed[i].typed, directed[i].angles);

    foreach (phases[i]) begin
      ph = phases[i];
      if (i == phases.size() - 1) begin
        ph.h = $urandom_range(32767, 1);
        ph.a = $urandom_range(32767, 1);
        ph.f = $urandom_range(32767, 1);
        ph.m = $urandom_range(32767);
      end
      load_geometry(ph);
      send_idle_pct = ph.send_idle;
      recv_idle_pct = ph.recv_idle;
      for (int n = 0; n < ph.count; n++) begin
        // in the first phase only, hold off once mid-phase until the unit has handed back everything
        if (i == 0 && n == ph.count / 2) begin
          wait (pending_angles.size() == 0);
          @(posedge clk_i);
        end
        send_random_target();
      end
    end

    wait (pending_angles.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
